FILE: hw/rtl/mts_pkg.sv
// Shared types and constants for the memory test sequencer.
`default_nettype none

package mts_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int COUNT_BITS  = OFFSET_BITS + 1;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = 32;
   localparam int INDEX_BITS  = 2;
   localparam int CSR_BITS    = 32;

   localparam logic [WORD_BITS-1:0]  PATTERN      = 32'hAAAA_AAAA;
   localparam logic [WORD_BITS-1:0]  ANTI_PATTERN = 32'h5555_5555;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = COUNT_BITS'(1) << OFFSET_BITS;

   localparam logic [INDEX_BITS-1:0] CSR_TEST_SELECT  = 2'd0;
   localparam logic [INDEX_BITS-1:0] CSR_BASE_ADDRESS = 2'd1;
   localparam logic [INDEX_BITS-1:0] CSR_WORD_COUNT   = 2'd2;

   localparam logic [1:0] TEST_DATA_BUS  = 2'd0;
   localparam logic [1:0] TEST_ADDR_BUS  = 2'd1;
   localparam logic [1:0] TEST_INTEGRITY = 2'd2;

   typedef enum logic [13:0] {
      PH_IDLE        = 14'b00000000000001,
      PH_DB_WRITE    = 14'b00000000000010,
      PH_DB_READ     = 14'b00000000000100,
      PH_AB_FILL     = 14'b00000000001000,
      PH_AB_ANTI0    = 14'b00000000010000,
      PH_AB_HIGH     = 14'b00000000100000,
      PH_AB_PAT0     = 14'b00000001000000,
      PH_AB_LOW_ANTI = 14'b00000010000000,
      PH_AB_LOW      = 14'b00000100000000,
      PH_AB_RESTORE  = 14'b00001000000000,
      PH_IN_FILL     = 14'b00010000000000,
      PH_IN_READ     = 14'b00100000000000,
      PH_IN_INVERT   = 14'b01000000000000,
      PH_IN_READ2    = 14'b10000000000000
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [COUNT_BITS-1:0]   sweep_offset;
      logic [OFFSET_BITS-1:0]  probe_offset;
      logic [WORD_BITS-1:0]    expected_word;
      logic                    read_pending;
      logic                    failure_seen;
      logic [OFFSET_BITS-1:0]  first_fail_offset;
      logic [WORD_BITS-1:0]    first_fail_word;
   } state_type;

   typedef struct packed {
      logic [1:0]              test_select;
      logic [ADDR_BITS-1:0]    base_address;
      logic [COUNT_BITS-1:0]   word_count;
   } cfg_type;

   typedef struct packed {
      logic                    access_valid;
      logic                    access_write;
      logic [ADDR_BITS-1:0]    access_address;
      logic [WORD_BITS-1:0]    write_data;
      logic                    busy_res;
      logic                    done_res;
      logic                    failed;
      logic [OFFSET_BITS-1:0]  fail_offset;
      logic [WORD_BITS-1:0]    fail_word;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:             PH_IDLE,
      sweep_offset:      '0,
      probe_offset:      '0,
      expected_word:     '0,
      read_pending:      1'b0,
      failure_seen:      1'b0,
      first_fail_offset: '0,
      first_fail_word:   '0
   };

endpackage

`default_nettype wire

FILE: hw/rtl/mts_csr.sv
// Configuration registers of the memory test sequencer.
`default_nettype none

module mts_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [mts_pkg::INDEX_BITS-1:0] csr_index,
   input  wire logic [mts_pkg::CSR_BITS-1:0]   csr_wdata,
   output mts_pkg::cfg_type                    cfg
);
   import mts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEST_SELECT:  cfg_in.test_select  = csr_wdata[1:0];
            CSR_BASE_ADDRESS: cfg_in.base_address = csr_wdata[ADDR_BITS-1:0];
            CSR_WORD_COUNT:   cfg_in.word_count   = csr_wdata[COUNT_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_select  <= TEST_DATA_BUS;
         cfg_ff.base_address <= '0;
         cfg_ff.word_count   <= COUNT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mts_step.sv
// Next-state and access logic for one step of the memory test sequencer.
`default_nettype none

module mts_step (
   input  wire mts_pkg::state_type            state,
   input  wire mts_pkg::cfg_type              cfg,
   input  wire logic                          start,
   input  wire logic [mts_pkg::WORD_BITS-1:0] read_data,
   output mts_pkg::state_type                 state_next,
   output mts_pkg::result_type                result
);
   import mts_pkg::*;

   function automatic state_type record_fail(input state_type s,
                                             input logic [OFFSET_BITS-1:0] off,
                                             input logic [WORD_BITS-1:0] rd);
      state_type r;
      r = s;
      if (!s.failure_seen) begin
         r.failure_seen      = 1'b1;
         r.first_fail_offset = off;
         r.first_fail_word   = rd;
      end
      return r;
   endfunction

   logic [COUNT_BITS-1:0] count;
   logic [COUNT_BITS-1:0] mask;

   always_comb begin
      if (cfg.word_count == '0) begin
         count = COUNT_BITS'(1);
      end else if (cfg.word_count > COUNT_MAX) begin
         count = COUNT_MAX;
      end else begin
         count = cfg.word_count;
      end
      mask = count - COUNT_BITS'(1);
   end

   state_type               nxt;
   logic                    fin;
   logic                    do_emit;
   logic                    acc_valid;
   logic                    acc_write;
   logic [COUNT_BITS-1:0]   acc_offset;
   logic [WORD_BITS-1:0]    acc_data;
   logic [COUNT_BITS-1:0]   step_next;
   logic [COUNT_BITS-1:0]   sweep_inc;
   logic [OFFSET_BITS-1:0]  probe_shift;

   always_comb begin
      nxt         = state;
      fin         = 1'b0;
      do_emit     = 1'b0;
      acc_valid   = 1'b0;
      acc_write   = 1'b0;
      acc_offset  = '0;
      acc_data    = '0;
      step_next   = '0;
      sweep_inc   = '0;
      probe_shift = '0;

      if (state.phase == PH_IDLE) begin
         nxt.phase        = PH_IDLE;
         nxt.read_pending = 1'b0;
         if (start) begin
            nxt.failure_seen      = 1'b0;
            nxt.first_fail_offset = '0;
            nxt.first_fail_word   = '0;
            nxt.probe_offset      = '0;
            case (cfg.test_select)
               TEST_DATA_BUS: begin
                  nxt.expected_word = WORD_BITS'(1);
                  nxt.sweep_offset  = '0;
                  nxt.phase         = PH_DB_WRITE;
               end
               TEST_ADDR_BUS: begin
                  nxt.sweep_offset = COUNT_BITS'(1);
                  nxt.phase        = mask[0] ? PH_AB_FILL : PH_AB_ANTI0;
               end
               TEST_INTEGRITY: begin
                  nxt.sweep_offset = '0;
                  nxt.phase        = PH_IN_FILL;
               end
               default: begin
                  fin       = 1'b1;
                  nxt.phase = PH_IDLE;
               end
            endcase
            do_emit = !fin;
         end
      end else begin
         if (state.read_pending) begin
            nxt.read_pending = 1'b0;
            case (state.phase)
               PH_DB_READ: begin
                  if (read_data != state.expected_word) begin
                     nxt       = record_fail(nxt, '0, read_data);
                     fin       = 1'b1;
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.expected_word = {state.expected_word[WORD_BITS-2:0], 1'b0};
                     if (nxt.expected_word == '0) begin
                        fin       = 1'b1;
                        nxt.phase = PH_IDLE;
                     end else begin
                        nxt.phase = PH_DB_WRITE;
                     end
                  end
               end
               PH_AB_HIGH: begin
                  if (read_data != PATTERN) begin
                     nxt = record_fail(nxt, state.sweep_offset[OFFSET_BITS-1:0], read_data);
                  end
                  step_next = {state.sweep_offset[OFFSET_BITS-1:0], 1'b0};
                  if ((step_next & mask) != '0) begin
                     nxt.sweep_offset = step_next;
                  end else if (nxt.failure_seen) begin
                     fin       = 1'b1;
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.phase = PH_AB_PAT0;
                  end
               end
               PH_AB_LOW: begin
                  if (read_data != PATTERN &&
                      state.sweep_offset != {1'b0, state.probe_offset}) begin
                     nxt = record_fail(nxt, state.sweep_offset[OFFSET_BITS-1:0], read_data);
                     nxt.phase = PH_AB_RESTORE;
                  end else begin
                     step_next = (state.sweep_offset == '0) ? COUNT_BITS'(1) :
                                 {state.sweep_offset[OFFSET_BITS-1:0], 1'b0};
                     if ((step_next & mask) != '0) begin
                        nxt.sweep_offset = step_next;
                     end else begin
                        nxt.phase = PH_AB_RESTORE;
                     end
                  end
               end
               PH_IN_READ: begin
                  if (read_data != state.expected_word) begin
                     nxt = record_fail(nxt, state.sweep_offset[OFFSET_BITS-1:0], read_data);
                  end
                  nxt.phase = PH_IN_INVERT;
               end
               PH_IN_READ2: begin
                  if (read_data != state.expected_word) begin
                     nxt = record_fail(nxt, state.sweep_offset[OFFSET_BITS-1:0], read_data);
                     fin       = 1'b1;
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.sweep_offset = state.sweep_offset + COUNT_BITS'(1);
                     if (nxt.sweep_offset >= count) begin
                        fin       = 1'b1;
                        nxt.phase = PH_IDLE;
                     end
                  end
               end
               default: begin
                  nxt.read_pending = 1'b0;
               end
            endcase
         end
         do_emit = !fin;
      end

      if (do_emit) begin
         sweep_inc = nxt.sweep_offset + COUNT_BITS'(1);
         case (nxt.phase)
            PH_DB_WRITE: begin
               acc_valid = 1'b1;
               acc_write = 1'b1;
               acc_data  = nxt.expected_word;
               nxt.phase = PH_DB_READ;
            end
            PH_DB_READ: begin
               acc_valid        = 1'b1;
               nxt.read_pending = 1'b1;
            end
            PH_AB_FILL: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_offset       = nxt.sweep_offset;
               acc_data         = PATTERN;
               nxt.sweep_offset = {nxt.sweep_offset[OFFSET_BITS-1:0], 1'b0};
               if ((nxt.sweep_offset & mask) == '0) begin
                  nxt.phase = PH_AB_ANTI0;
               end
            end
            PH_AB_ANTI0: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_data         = ANTI_PATTERN;
               nxt.sweep_offset = COUNT_BITS'(1);
               nxt.phase        = mask[0] ? PH_AB_HIGH : PH_AB_PAT0;
            end
            PH_AB_HIGH, PH_AB_LOW: begin
               acc_valid         = 1'b1;
               acc_offset        = nxt.sweep_offset;
               nxt.expected_word = PATTERN;
               nxt.read_pending  = 1'b1;
            end
            PH_AB_PAT0: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_data         = PATTERN;
               nxt.probe_offset = OFFSET_BITS'(1);
               if (mask[0]) begin
                  nxt.phase = PH_AB_LOW_ANTI;
               end else begin
                  fin       = 1'b1;
                  nxt.phase = PH_IDLE;
               end
            end
            PH_AB_LOW_ANTI: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_offset       = {1'b0, nxt.probe_offset};
               acc_data         = ANTI_PATTERN;
               nxt.sweep_offset = '0;
               nxt.phase        = PH_AB_LOW;
            end
            PH_AB_RESTORE: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_offset       = {1'b0, nxt.probe_offset};
               acc_data         = PATTERN;
               probe_shift      = {nxt.probe_offset[OFFSET_BITS-2:0], 1'b0};
               nxt.probe_offset = probe_shift;
               if (nxt.failure_seen || (probe_shift & mask[OFFSET_BITS-1:0]) == '0) begin
                  fin       = 1'b1;
                  nxt.phase = PH_IDLE;
               end else begin
                  nxt.phase = PH_AB_LOW_ANTI;
               end
            end
            PH_IN_FILL: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_offset       = nxt.sweep_offset;
               acc_data         = WORD_BITS'(sweep_inc);
               nxt.sweep_offset = sweep_inc;
               if (sweep_inc >= count) begin
                  nxt.sweep_offset = '0;
                  nxt.phase        = PH_IN_READ;
               end
            end
            PH_IN_READ: begin
               acc_valid         = 1'b1;
               acc_offset        = nxt.sweep_offset;
               nxt.expected_word = WORD_BITS'(sweep_inc);
               nxt.read_pending  = 1'b1;
            end
            PH_IN_INVERT: begin
               acc_valid        = 1'b1;
               acc_write        = 1'b1;
               acc_offset       = nxt.sweep_offset;
               acc_data         = ~nxt.expected_word;
               nxt.sweep_offset = sweep_inc;
               if (nxt.failure_seen) begin
                  fin       = 1'b1;
                  nxt.phase = PH_IDLE;
               end else if (sweep_inc >= count) begin
                  nxt.sweep_offset = '0;
                  nxt.phase        = PH_IN_READ2;
               end else begin
                  nxt.phase = PH_IN_READ;
               end
            end
            PH_IN_READ2: begin
               acc_valid         = 1'b1;
               acc_offset        = nxt.sweep_offset;
               nxt.expected_word = ~WORD_BITS'(sweep_inc);
               nxt.read_pending  = 1'b1;
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      state_next            = nxt;
      result.access_valid   = acc_valid;
      result.access_write   = acc_write;
      result.access_address = acc_valid ?
                              cfg.base_address + ADDR_BITS'(acc_offset) : '0;
      result.write_data     = acc_data;
      result.busy_res       = (nxt.phase != PH_IDLE);
      result.done_res       = fin;
      result.failed         = nxt.failure_seen;
      result.fail_offset    = nxt.first_fail_offset;
      result.fail_word      = nxt.first_fail_word;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/memory_test_sequencer_core.sv
// Memory test sequencer: item register, step logic and result register.
// Each accepted item is held in the item register and its result in the result register.
// Throughput: one item per cycle while rsp_tready is high; the test state is updated as each item
// leaves the item register, so the next item sees it in the following cycle.
// Reset (synchronous): test idle, failure record cleared, configuration
// test_select 0, base_address 0, word_count 65536; no clearing pass.
`default_nettype none

module memory_test_sequencer_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // read_data
   input  wire logic         req_tuser,   // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // access_valid, access_write, access_address, write_data, busy_res,
   // done_res, failed, fail_offset, fail_word, zero pad
   output logic [119:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [mts_pkg::INDEX_BITS-1:0] csr_index,
   input  wire logic [mts_pkg::CSR_BITS-1:0]   csr_wdata
);
   import mts_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       item_valid_ff;
   logic       item_start_ff;
   logic [WORD_BITS-1:0] item_data_ff;
   logic       step_go;

   mts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mts_step u_step (
      .state      (state_ff),
      .cfg        (cfg),
      .start      (item_start_ff),
      .read_data  (item_data_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   assign step_go    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         item_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            item_valid_ff <= 1'b1;
            item_start_ff <= req_tuser;
         end else if (step_go) begin
            item_valid_ff <= 1'b0;
         end
         if (step_go) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_data_ff <= req_tdata[WORD_BITS-1:0];
      end
      if (step_go) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.fail_word,
                        rsp_ff.fail_offset,
                        rsp_ff.failed,
                        rsp_ff.done_res,
                        rsp_ff.busy_res,
                        rsp_ff.write_data,
                        rsp_ff.access_address,
                        rsp_ff.access_write,
                        rsp_ff.access_valid};

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_write_is_access: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.access_write |-> rsp_ff.access_valid)
      else $error("write flagged without an access");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> !state_ff.read_pending)
      else $error("read pending while idle");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(step_go) && !$past(reset) |-> $stable(state_ff))
      else $error("test state changed without a step");

endmodule

`default_nettype wire
